// ----- rtl/sosc_pkg.sv -----
// Shared types, codes and constants of the scan obstacle side classifier.
`default_nettype none

package sosc_pkg;

  localparam int RangeW      = 16;
  localparam int AngleW      = 10;
  localparam int ClassW      = 3;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 16;
  localparam int MaxBeamsDef = 1024;

  // Stream packing widths (tdata padded to whole bytes).
  localparam int InDataW  = 24;
  localparam int InUserW  = 2;
  localparam int OutDataW = 8;

  localparam logic [RangeW-1:0] NearLimitRst = 16'd605;
  localparam logic [AngleW-1:0] ZeroAngleRst = 10'd512;

  localparam logic [CfgIdxW-1:0] CFG_NEAR_LIMIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_ANGLE = 1'b1;

  localparam logic OP_BEAM = 1'b0;
  localparam logic OP_BUMP = 1'b1;

  typedef enum logic [ClassW-1:0] {
    CLS_NONE = 3'd0,
    CLS_NEG  = 3'd1,
    CLS_POS  = 3'd2,
    CLS_BOTH = 3'd3,
    CLS_HIT  = 3'd4
  } class_e;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_TRACK  = 3'b010,
    PH_SKIP   = 3'b100
  } phase_e;

  typedef struct packed {
    logic              op;
    logic [RangeW-1:0] range_mm;
    logic              no_return;
    logic              last_beam;
    logic              bump_pressed;
  } item_t;

  typedef struct packed {
    logic [RangeW-1:0] near_limit_mm;
    logic [AngleW-1:0] zero_angle_beam;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/sosc_track.sv -----
// Run tracker and per-scan side flags; classifies the scan at its last beam.
`default_nettype none

module sosc_track #(
  parameter int MaxBeams = sosc_pkg::MaxBeamsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire sosc_pkg::item_t item_i,
  input  wire sosc_pkg::cfg_t  cfg_i,
  output sosc_pkg::class_e     class_o
);
  import sosc_pkg::*;

  localparam int IdxW = $clog2(MaxBeams);
  localparam int CmpW = (IdxW > AngleW) ? IdxW : AngleW;
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MaxBeams - 1);

  phase_e            phase_q, phase_d;
  logic [RangeW-1:0] least_range_q, least_range_d;
  logic [IdxW-1:0]   least_index_q, least_index_d;
  logic [IdxW-1:0]   beam_index_q, beam_index_d;
  logic              neg_q, neg_d, pos_q, pos_d;
  logic              bump_q, bump_d;

  logic is_near;
  logic neg_now;
  logic neg_end;
  logic pos_end;
  logic [CmpW-1:0] zero_ext;

  assign is_near  = !item_i.no_return && (item_i.range_mm < cfg_i.near_limit_mm);
  assign zero_ext = CmpW'(cfg_i.zero_angle_beam);
  assign neg_now  = CmpW'(least_index_q) < zero_ext;

  always_comb begin
    phase_d       = phase_q;
    least_range_d = least_range_q;
    least_index_d = least_index_q;
    beam_index_d  = beam_index_q;
    neg_d         = neg_q;
    pos_d         = pos_q;
    bump_d        = bump_q;
    neg_end       = neg_q;
    pos_end       = pos_q;
    class_o       = CLS_NONE;

    if (step_i && item_i.op == OP_BUMP) begin
      bump_d = item_i.bump_pressed;
    end else if (step_i) begin
      case (phase_q)
        PH_TRACK: begin
          if (is_near) begin
            if (item_i.range_mm <= least_range_q) begin
              least_range_d = item_i.range_mm;
              least_index_d = beam_index_q;
            end else begin
              // run ended on a rising reading: place it by its minimum
              neg_d   = neg_q | neg_now;
              pos_d   = pos_q | !neg_now;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (!is_near) phase_d = PH_SEARCH;
        end
        default: begin
          phase_d = PH_SEARCH;
          if (is_near) begin
            least_range_d = item_i.range_mm;
            least_index_d = beam_index_q;
            phase_d       = PH_TRACK;
          end
        end
      endcase

      if (beam_index_q != IdxMax) beam_index_d = beam_index_q + IdxW'(1);

      // count a run still open at the last beam
      neg_end = neg_d;
      pos_end = pos_d;
      if (phase_d == PH_TRACK) begin
        if (CmpW'(least_index_d) < zero_ext) neg_end = 1'b1;
        else                                 pos_end = 1'b1;
      end

      if (bump_q)                class_o = CLS_HIT;
      else if (neg_end && pos_end) class_o = CLS_BOTH;
      else if (neg_end)          class_o = CLS_NEG;
      else if (pos_end)          class_o = CLS_POS;
      else                       class_o = CLS_NONE;

      if (item_i.last_beam) begin
        phase_d       = PH_SEARCH;
        least_range_d = '0;
        least_index_d = '0;
        beam_index_d  = '0;
        neg_d         = 1'b0;
        pos_d         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SEARCH;
      least_range_q <= '0;
      least_index_q <= '0;
      beam_index_q  <= '0;
      neg_q         <= 1'b0;
      pos_q         <= 1'b0;
      bump_q        <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      least_range_q <= least_range_d;
      least_index_q <= least_index_d;
      beam_index_q  <= beam_index_d;
      neg_q         <= neg_d;
      pos_q         <= pos_d;
      bump_q        <= bump_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scan_obstacle_side_classifier.sv -----
// Top level of the scan obstacle side classifier: stream ports, config, pipeline.
// Usage:
//   Slave stream carries one transaction per beam or bumper event. tuser[0] is
//   the op (0 beam, 1 bumper), tuser[1] the no-return flag, tlast marks the
//   final beam of a scan; tdata holds range_mm in [15:0] and bump_pressed in [16].
//   Master stream carries one transaction per scan, issued on the last beam:
//   tdata[2:0] is the class (none, negative side, positive side, both, hit abort).
//   Config port: write cfg_wdata_i into register cfg_idx_i when cfg_we_i is high
//   (0 near limit in mm, 1 first beam index of the positive side). Write only
//   while the block is idle.
// Timing:
//   One transaction per cycle unless a last beam waits on a full output register.
//   A beam is captured in the input register and then runs one compare/update
//   pass, which for a last beam also loads the output register driving m_axis_tvalid.
// Reset:
//   Clears scan state, bumper latch, both pipeline valids and restores the
//   register defaults (605 mm, beam 512).
// Backpressure:
//   A waiting result holds on the output register; beams and bumper events that
//   make no result keep flowing under it. Only a second last beam stalls.
`default_nettype none

module scan_obstacle_side_classifier #(
  parameter int MaxBeams = sosc_pkg::MaxBeamsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [sosc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sosc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // slave stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [sosc_pkg::InDataW-1:0]  s_axis_tdata,  // range_mm, bump_pressed, pad
  input  wire logic [sosc_pkg::InUserW-1:0]  s_axis_tuser,  // op, no_return
  input  wire logic                          s_axis_tlast,
  // master stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [sosc_pkg::OutDataW-1:0]      m_axis_tdata   // obstacle_class, pad
);
  import sosc_pkg::*;

  cfg_t   cfg_q;
  item_t  in_q;
  logic   in_valid_q;
  logic   out_valid_q;
  class_e out_class_q;
  class_e trk_class;

  logic s_accept;
  logic gives_result;
  logic proc_fire;

  // config registers; both indexes are decoded, so the default arm is never taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_limit_mm   <= NearLimitRst;
      cfg_q.zero_angle_beam <= ZeroAngleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEAR_LIMIT: cfg_q.near_limit_mm   <= cfg_wdata_i[RangeW-1:0];
        CFG_ZERO_ANGLE: cfg_q.zero_angle_beam <= cfg_wdata_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // Only a last beam produces a result, so only it waits on the output register.
  assign gives_result  = (in_q.op == OP_BEAM) && in_q.last_beam;
  assign proc_fire     = in_valid_q && (!gives_result || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload register: no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.op           <= s_axis_tuser[0];
      in_q.no_return    <= s_axis_tuser[1];
      in_q.range_mm     <= s_axis_tdata[RangeW-1:0];
      in_q.bump_pressed <= s_axis_tdata[RangeW];
      in_q.last_beam    <= s_axis_tlast;
    end
  end

  sosc_track #(
    .MaxBeams(MaxBeams)
  ) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (proc_fire),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .class_o(trk_class)
  );

  // output register: load a fresh class, drop a taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && gives_result) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && gives_result) out_class_q <= trk_class;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-ClassW){1'b0}}, out_class_q};

endmodule

`default_nettype wire

// ----- rtl/sosc_checker.sv -----
// Port-level checks on the scan obstacle side classifier, bound to the top level.
`default_nettype none

module sosc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [sosc_pkg::OutDataW-1:0] m_axis_tdata
);
  import sosc_pkg::*;

  // class code is one of the five defined values and padding stays zero
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ClassW-1:0] <= CLS_HIT) &&
                      (m_axis_tdata[OutDataW-1:ClassW] == '0))
    else $error("obstacle class out of range");

  // with the output register empty the block must take input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled result holds its value
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind scan_obstacle_side_classifier sosc_checker u_sosc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
